// ----- design/upsd_pkg.sv -----
`default_nettype none

package upsd_pkg;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharQuest   = 8'h3F;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowF    = 8'h66;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpF     = 8'h46;
  localparam logic [7:0] HexLetterOfs = 8'd10;

  localparam int unsigned LenW      = 16;
  localparam int unsigned MaxBytes  = 3;
  localparam int unsigned NbW       = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef enum logic [2:0] {
    EscIdle = 3'b001,
    EscPct  = 3'b010,
    EscHex  = 3'b100
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_valid;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            out_valid;
    logic            in_query_part;
    logic            end_marker;
    logic            query_present;
    logic [LenW-1:0] decoded_path_length;
  } out_word_t;

  // everything one input word produces: up to three bytes, then maybe the end marker
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [NbW-1:0]           n_bytes;
    logic                     query;
    logic                     last;
    logic                     query_seen;
    logic [LenW-1:0]          path_cnt;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } fifo_ctl_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [7:0] t;
    logic [4:0] r;
    t = 8'd0;
    r = 5'd0;
    if (c >= CharZero && c <= CharNine) begin
      t = c - CharZero;
      r = {1'b1, t[3:0]};
    end else if (c >= CharLowA && c <= CharLowF) begin
      t = c - CharLowA + HexLetterOfs;
      r = {1'b1, t[3:0]};
    end else if (c >= CharUpA && c <= CharUpF) begin
      t = c - CharUpA + HexLetterOfs;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/upsd_if.sv -----
`default_nettype none

interface upsd_in_if;
  logic               valid;
  logic               ready;
  upsd_pkg::in_word_t data;

  modport src  (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface upsd_out_if;
  logic                valid;
  logic                ready;
  upsd_pkg::out_word_t data;

  modport src  (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/upsd_front.sv -----
`default_nettype none

module upsd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire upsd_pkg::in_word_t  word_i,
  output logic                     ready_o,
  input  wire logic                full_i,
  output logic                     push_o,
  output upsd_pkg::job_t           job_o
);

  upsd_pkg::esc_phase_e              phase_q, phase_d;
  logic [7:0]                        held_q, held_d;
  logic                              seen_q, seen_d;
  logic [upsd_pkg::LenW-1:0]         count_q, count_d;

  logic                              accept;
  logic [upsd_pkg::MaxBytes-1:0][7:0] bytes_v;
  logic [upsd_pkg::NbW-1:0]          n_v;
  logic                              query_v;
  logic                              do_plain;
  logic [4:0]                        hex_in;
  logic [4:0]                        hex_held;
  logic [upsd_pkg::LenW:0]           sum;
  logic [upsd_pkg::LenW-1:0]         count_v;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign hex_in   = upsd_pkg::hex_nibble(word_i.in_byte);
  assign hex_held = upsd_pkg::hex_nibble(held_q);

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    seen_d   = seen_q;
    bytes_v  = '0;
    n_v      = '0;
    query_v  = 1'b0;
    do_plain = 1'b0;

    if (word_i.byte_valid) begin
      if (seen_q) begin
        bytes_v[n_v] = word_i.in_byte;
        n_v          = n_v + 1'b1;
        query_v      = 1'b1;
      end else begin
        unique case (phase_q)
          upsd_pkg::EscPct: begin
            if (hex_in[4]) begin
              held_d  = word_i.in_byte;
              phase_d = upsd_pkg::EscHex;
            end else begin
              phase_d      = upsd_pkg::EscIdle;
              bytes_v[n_v] = upsd_pkg::CharPercent;
              n_v          = n_v + 1'b1;
              do_plain     = 1'b1;
            end
          end
          upsd_pkg::EscHex: begin
            phase_d = upsd_pkg::EscIdle;
            if (hex_held[4] && hex_in[4]) begin
              bytes_v[n_v] = {hex_held[3:0], hex_in[3:0]};
              n_v          = n_v + 1'b1;
            end else begin
              bytes_v[n_v] = upsd_pkg::CharPercent;
              n_v          = n_v + 1'b1;
              bytes_v[n_v] = held_q;
              n_v          = n_v + 1'b1;
              do_plain     = 1'b1;
            end
          end
          default: begin
            phase_d  = upsd_pkg::EscIdle;
            do_plain = 1'b1;
          end
        endcase
      end
    end

    // the breaking byte (or a fresh one) goes through plain path handling
    if (do_plain) begin
      priority if (word_i.in_byte == upsd_pkg::CharQuest) begin
        seen_d = 1'b1;
      end else if (word_i.in_byte == upsd_pkg::CharPercent) begin
        phase_d = upsd_pkg::EscPct;
      end else if (word_i.in_byte == upsd_pkg::CharPlus) begin
        bytes_v[n_v] = upsd_pkg::CharSpace;
        n_v          = n_v + 1'b1;
      end else begin
        bytes_v[n_v] = word_i.in_byte;
        n_v          = n_v + 1'b1;
      end
    end

    // flush an open escape at end of URL, then start afresh
    if (word_i.is_last) begin
      if (phase_d == upsd_pkg::EscPct) begin
        bytes_v[n_v] = upsd_pkg::CharPercent;
        n_v          = n_v + 1'b1;
      end else if (phase_d == upsd_pkg::EscHex) begin
        bytes_v[n_v] = upsd_pkg::CharPercent;
        n_v          = n_v + 1'b1;
        bytes_v[n_v] = held_d;
        n_v          = n_v + 1'b1;
      end
      phase_d = upsd_pkg::EscIdle;
      held_d  = '0;
      seen_d  = 1'b0;
    end
  end

  // saturating path count
  always_comb begin
    sum = {1'b0, count_q};
    if (!query_v) begin
      sum = {1'b0, count_q} + (upsd_pkg::LenW + 1)'(n_v);
    end
    count_v = sum[upsd_pkg::LenW] ? '1 : sum[upsd_pkg::LenW-1:0];
  end

  always_comb begin
    count_d = count_v;
    if (word_i.is_last) begin
      count_d = '0;
    end
  end

  assign push_o = accept && ((n_v != '0) || word_i.is_last);

  always_comb begin
    job_o.bytes      = bytes_v;
    job_o.n_bytes    = n_v;
    job_o.query      = query_v;
    job_o.last       = word_i.is_last;
    job_o.query_seen = seen_q || (do_plain && word_i.in_byte == upsd_pkg::CharQuest);
    job_o.path_cnt   = count_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upsd_pkg::EscIdle;
      held_q  <= '0;
      seen_q  <= 1'b0;
      count_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      seen_q  <= seen_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/upsd_fifo.sv -----
`default_nettype none

module upsd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire upsd_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output upsd_pkg::job_t      head_o
);

  upsd_pkg::job_t                   mem_q [upsd_pkg::FifoDepth];
  logic [upsd_pkg::FifoAw-1:0]      wr_q, rd_q;
  logic [upsd_pkg::FifoCntW-1:0]    cnt_q, cnt_d;
  upsd_pkg::fifo_ctl_t              ctl;

  assign full_o  = ctl.full;
  assign empty_o = ctl.empty;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    ctl.full  = (cnt_q == upsd_pkg::FifoCntW'(upsd_pkg::FifoDepth));
    ctl.empty = (cnt_q == '0);
    ctl.push  = push_i && !ctl.full;
    ctl.pop   = pop_i && !ctl.empty;
    cnt_d     = cnt_q;
    unique case ({ctl.push, ctl.pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (ctl.push) wr_q <= wr_q + 1'b1;
      if (ctl.pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/upsd_back.sv -----
`default_nettype none

module upsd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire upsd_pkg::job_t head_i,
  output logic                pop_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output upsd_pkg::out_word_t word_o
);

  logic [upsd_pkg::NbW-1:0] idx_q;
  logic [upsd_pkg::NbW:0]   n_res;
  logic [upsd_pkg::NbW-1:0] last_idx;
  logic                     is_byte;
  logic                     fire;

  assign n_res    = {1'b0, head_i.n_bytes} + {{upsd_pkg::NbW{1'b0}}, head_i.last};
  assign last_idx = upsd_pkg::NbW'(n_res - 1'b1);
  assign is_byte  = (idx_q < head_i.n_bytes);
  assign valid_o  = !empty_i;
  assign fire     = valid_o && ready_i;
  assign pop_o    = fire && (idx_q == last_idx);

  always_comb begin
    word_o = '0;
    if (is_byte) begin
      word_o.out_byte      = head_i.bytes[idx_q];
      word_o.out_valid     = 1'b1;
      word_o.in_query_part = head_i.query;
    end else begin
      word_o.end_marker          = 1'b1;
      word_o.query_present       = head_i.query_seen;
      word_o.decoded_path_length = head_i.path_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= pop_o ? '0 : idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/url_path_split_percent_decoder_core.sv -----
// channel  dir  modport           payload
// in_i     in   upsd_in_if.sink   in_byte, byte_valid, is_last
// out_o    out  upsd_out_if.src   out_byte, out_valid, in_query_part, end_marker,
//                                 query_present, decoded_path_length
//
// One input word per cycle; the front decodes it in the cycle it is taken.
// Each word yields 0..4 output words, sent one a cycle from a 4-deep job queue.
// in_i.ready drops only when that queue is full; out_o.ready stalls the back only.
// Async active-low reset empties the queue and clears escape, query and count state.
`default_nettype none

module url_path_split_percent_decoder_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  upsd_in_if.sink   in_i,
  upsd_out_if.src   out_o
);

  upsd_pkg::job_t job_w, head_w;
  logic           push_w, full_w, pop_w, empty_w;

  upsd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .word_i  (in_i.data),
    .ready_o (in_i.ready),
    .full_i  (full_w),
    .push_o  (push_w),
    .job_o   (job_w)
  );

  upsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .job_i   (job_w),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .empty_o (empty_w),
    .head_o  (head_w)
  );

  upsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty_w),
    .head_i  (head_w),
    .pop_o   (pop_w),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .word_o  (out_o.data)
  );

endmodule

`default_nettype wire

// ----- design/upsd_checker.sv -----
`default_nettype none

module upsd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire upsd_pkg::out_word_t out_data_i
);

  logic                      fire;
  logic                      qbyte_q;
  logic [upsd_pkg::LenW-1:0] plen_q;

  assign fire = out_valid_i && out_ready_i;

  // shadow of the current URL as seen on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qbyte_q <= 1'b0;
      plen_q  <= '0;
    end else if (fire) begin
      if (out_data_i.end_marker) begin
        qbyte_q <= 1'b0;
        plen_q  <= '0;
      end else if (out_data_i.in_query_part) begin
        qbyte_q <= 1'b1;
      end else if (plen_q != '1) begin
        plen_q <= plen_q + 1'b1;
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  a_no_path_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && qbyte_q && out_data_i.out_valid |-> out_data_i.in_query_part)
    else $error("path byte after a query byte");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_data_i.end_marker |-> out_data_i.decoded_path_length == plen_q)
    else $error("end marker length disagrees with path bytes sent");

  a_qp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_data_i.end_marker && qbyte_q |-> out_data_i.query_present)
    else $error("query bytes sent but no query flagged");

endmodule

bind url_path_split_percent_decoder_core upsd_checker u_upsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
